// ===== hdl/lmbc_pkg.sv =====
// shared types, codes and lookup functions of the label map border classifier
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package lmbc_pkg;

	localparam int LABEL_W = 16;
	localparam int CFG_W = 11;
	localparam int SCORE_W = 7;
	localparam int CLASS_W = 3;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_LABEL_BITS = 16;

	localparam int WIDTH_RESET = 640;
	localparam int HEIGHT_RESET = 480;

	localparam int CMDQ_DEPTH = 4;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [SCORE_W-1:0] WEIGHT_SIDE = SCORE_W'(1);
	localparam logic [SCORE_W-1:0] WEIGHT_CORNER = SCORE_W'(4);
	localparam logic [SCORE_W-1:0] WEIGHT_EDGE = SCORE_W'(16);

	localparam logic [SCORE_W-1:0] SCORE_STRAIGHT = SCORE_W'(2);
	localparam logic [SCORE_W-1:0] SCORE_OUTER = SCORE_W'(5);
	localparam logic [SCORE_W-1:0] SCORE_INNER = SCORE_W'(6);
	localparam logic [SCORE_W-1:0] SCORE_END = SCORE_W'(9);
	localparam logic [SCORE_W-1:0] SCORE_DIAG = SCORE_W'(12);
	localparam logic [SCORE_W-1:0] SCORE_EDGE_MIN = SCORE_W'(16);

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_NONE = 3'd0,
		CLS_STRAIGHT = 3'd1,
		CLS_OUTER = 3'd2,
		CLS_INNER = 3'd3,
		CLS_END = 3'd4,
		CLS_DIAG = 3'd5,
		CLS_EDGE = 3'd6
	} pixel_class_t;

	typedef struct packed {
		logic op;
		logic [LABEL_W-1:0] label;
	} in_item_t;

	typedef struct packed {
		logic [CLASS_W-1:0] pixel_class;
		logic frame_last;
	} out_item_t;

	// what the back end does with one queued entry
	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_DRAIN_TL = 2'd1,
		CMD_DRAIN_MEM = 2'd2,
		CMD_DRAIN_BL = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [LABEL_W-1:0] label;
		logic window;
		logic emit;
		logic last;
	} cmd_t;

	function automatic logic [SCORE_W-1:0] ring_weight(input logic [3:0] code);
		logic [SCORE_W-1:0] w;
		unique case (code) inside
			4'd3, 4'd6, 4'd9, 4'd12: w = WEIGHT_CORNER;
			4'd5, 4'd10: w = WEIGHT_SIDE;
			4'd7, 4'd11, 4'd13, 4'd14, 4'd15: w = WEIGHT_EDGE;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic pixel_class_t classify(input logic [SCORE_W-1:0] score);
		pixel_class_t cls;
		unique case (score) inside
			SCORE_STRAIGHT: cls = CLS_STRAIGHT;
			SCORE_OUTER: cls = CLS_OUTER;
			SCORE_INNER: cls = CLS_INNER;
			SCORE_END: cls = CLS_END;
			SCORE_DIAG: cls = CLS_DIAG;
			default: cls = (score > SCORE_EDGE_MIN) ? CLS_EDGE : CLS_NONE;
		endcase
		return cls;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lmbc_front.sv =====
// front end: accepts items, tracks raster position and drain phase, queues commands
// depends on lmbc_pkg
`default_nettype none

module lmbc_front #(
	parameter int MAX_WIDTH = lmbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lmbc_pkg::DEF_MAX_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic restart,
	input wire logic [$clog2(MAX_WIDTH+1)-1:0] width,
	input wire logic [$clog2(MAX_HEIGHT+1)-1:0] height,
	input wire logic in_valid,
	input wire logic hold,
	input wire lmbc_pkg::in_item_t in_data,
	output logic cmd_push,
	output lmbc_pkg::cmd_t cmd
);

	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic draining_q;
	logic [WDIM_W-1:0] drain_cnt_q;

	logic accept;
	logic row_end;
	logic frame_end;
	logic drain_end;

	assign accept = in_valid && !hold;
	assign row_end = (WDIM_W'(col_q) == (width - WDIM_W'(1)));
	assign frame_end = (HDIM_W'(row_q) == (height - HDIM_W'(1)));
	assign drain_end = (drain_cnt_q == width);

	// a flush outside the drain phase is taken and dropped
	assign cmd_push = accept && (draining_q || (in_data.op == lmbc_pkg::OP_PIXEL));

	always_comb begin
		cmd.label = in_data.label;
		if (draining_q) begin
			cmd.window = 1'b0;
			cmd.emit = 1'b1;
			cmd.last = drain_end;
			if (drain_cnt_q == '0) begin
				cmd.kind = lmbc_pkg::CMD_DRAIN_TL;
			end else if (drain_end) begin
				cmd.kind = lmbc_pkg::CMD_DRAIN_BL;
			end else begin
				cmd.kind = lmbc_pkg::CMD_DRAIN_MEM;
			end
		end else begin
			cmd.kind = lmbc_pkg::CMD_PIXEL;
			cmd.window = (row_q != '0) && (col_q != '0);
			// the upper-left neighbor is complete once a full row plus one has passed
			cmd.emit = (row_q != '0) && ((row_q != ROW_W'(1)) || (col_q != '0));
			cmd.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			draining_q <= 1'b0;
			drain_cnt_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			draining_q <= 1'b0;
			drain_cnt_q <= '0;
		end else if (cmd_push) begin
			if (draining_q) begin
				if (drain_end) begin
					draining_q <= 1'b0;
					drain_cnt_q <= '0;
				end else begin
					drain_cnt_q <= drain_cnt_q + WDIM_W'(1);
				end
			end else if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
					draining_q <= 1'b1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lmbc_cmd_queue.sv =====
// short command queue between front and back end
// depends on lmbc_pkg
`default_nettype none

module lmbc_cmd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire lmbc_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output lmbc_pkg::cmd_t head_cmd
);

	localparam int DEPTH = lmbc_pkg::CMDQ_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lmbc_pkg::cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lmbc_back.sv =====
// back end: line buffer, 2x2 window scoring, classification and output register
// depends on lmbc_pkg
`default_nettype none

module lmbc_back #(
	parameter int MAX_WIDTH = lmbc_pkg::DEF_MAX_WIDTH,
	parameter int LABEL_BITS = lmbc_pkg::DEF_LABEL_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic restart,
	input wire logic [$clog2(MAX_WIDTH+1)-1:0] width,
	input wire logic head_valid,
	input wire lmbc_pkg::cmd_t head_cmd,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output lmbc_pkg::out_item_t out_data
);

	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int RING_DEPTH = MAX_WIDTH - 1;
	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int LBL_W = (LABEL_BITS < lmbc_pkg::LABEL_W) ? LABEL_BITS : lmbc_pkg::LABEL_W;
	localparam int SC_W = lmbc_pkg::SCORE_W;
	localparam int ENT_W = LBL_W + SC_W;

	// holds the row above, from one right of the upper-left pixel up to two back
	logic [ENT_W-1:0] mem [RING_DEPTH];
	logic [PTR_W-1:0] ptr_q;
	logic [ENT_W-1:0] rd_data_q;

	logic [LBL_W-1:0] tl_label_q;
	logic [SC_W-1:0] tl_score_q;
	logic [LBL_W-1:0] bl_label_q;
	logic [SC_W-1:0] bl_score_q;

	logic out_valid_q;
	lmbc_pkg::out_item_t out_data_q;

	logic [LBL_W-1:0] tr_label;
	logic [SC_W-1:0] tr_score;
	logic [LBL_W-1:0] br_label;
	logic [3:0] code;
	logic [SC_W-1:0] weight;
	logic is_pixel;
	logic step;
	logic ptr_wrap;
	logic [PTR_W-1:0] ptr_next;
	logic mem_we;
	logic [ENT_W-1:0] mem_wdata;
	logic [SC_W-1:0] emit_score;

	assign pop = head_valid && (!out_valid_q || !out_stall);

	assign tr_label = rd_data_q[ENT_W-1:SC_W];
	assign tr_score = rd_data_q[SC_W-1:0];
	assign br_label = head_cmd.label[LBL_W-1:0];

	// ring code around the window: top, right, bottom, left edges
	assign code = {bl_label_q != tl_label_q, br_label != bl_label_q,
		tr_label != br_label, tl_label_q != tr_label};
	assign weight = head_cmd.window ? lmbc_pkg::ring_weight(code) : '0;

	assign is_pixel = (head_cmd.kind == lmbc_pkg::CMD_PIXEL);
	assign step = pop && (is_pixel || (head_cmd.kind == lmbc_pkg::CMD_DRAIN_MEM));
	assign ptr_wrap = (ptr_q == PTR_W'(width - WDIM_W'(2)));

	always_comb begin
		if (restart || (pop && head_cmd.last)) begin
			ptr_next = '0;
		end else if (step) begin
			ptr_next = ptr_wrap ? '0 : (ptr_q + PTR_W'(1));
		end else begin
			ptr_next = ptr_q;
		end
	end

	// the left neighbor has its last pending weight now and goes into the line
	assign mem_we = pop && is_pixel;
	assign mem_wdata = {bl_label_q, bl_score_q + weight};

	always_comb begin
		case (head_cmd.kind)
			lmbc_pkg::CMD_PIXEL: emit_score = tl_score_q + weight;
			lmbc_pkg::CMD_DRAIN_TL: emit_score = tl_score_q;
			lmbc_pkg::CMD_DRAIN_MEM: emit_score = tr_score;
			default: emit_score = bl_score_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ptr_q] <= mem_wdata;
		end
	end

	// read data always mirrors the entry at the pointer, write-first on a hit
	always_ff @(posedge clk) begin
		if (mem_we && (ptr_q == ptr_next)) begin
			rd_data_q <= mem_wdata;
		end else begin
			rd_data_q <= mem[ptr_next];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tl_label_q <= tr_label;
			tl_score_q <= tr_score + weight;
			bl_label_q <= br_label;
			bl_score_q <= weight;
		end
		if (pop && head_cmd.emit) begin
			out_data_q.pixel_class <= lmbc_pkg::classify(emit_score);
			out_data_q.frame_last <= head_cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q <= ptr_next;
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= pop && head_cmd.emit;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/label_map_border_classifier.sv =====
// top level of the label map border classifier: config registers, front, queue, back
// depends on lmbc_pkg, lmbc_front, lmbc_cmd_queue, lmbc_back
`default_nettype none

// Takes one label pixel per cycle in raster order and returns one border class per pixel,
// width+1 items after the pixel went in; flush items drain the last width+1 pixels and the
// final result carries frame_last. Each pixel costs one read-modify-write of a single
// line-buffer entry (MAX_WIDTH-1 entries of label and score), and the back end does that for
// each popped command, so the sustained rate is one item per clock while neither side stalls;
// the command that causes a result passes the command queue, and the result is then registered
// in the output register. A short command queue separates input and output, so in_stall
// rises only after out_stall has held the output register and the queue has filled. Flush
// items outside the drain phase are taken and dropped. The line buffer needs no clearing
// after reset. Configuration writes restart the frame and must be made only while no
// transfer is in flight.
module label_map_border_classifier #(
	parameter int MAX_WIDTH = lmbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lmbc_pkg::DEF_MAX_HEIGHT,
	parameter int LABEL_BITS = lmbc_pkg::DEF_LABEL_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire lmbc_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output lmbc_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire lmbc_pkg::cfg_reg_t cfg_index,
	input wire logic [lmbc_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
	localparam int WIDTH_INIT = (lmbc_pkg::WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : lmbc_pkg::WIDTH_RESET;
	localparam int HEIGHT_INIT = (lmbc_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
		MAX_HEIGHT : lmbc_pkg::HEIGHT_RESET;

	logic [WDIM_W-1:0] width_q;
	logic [HDIM_W-1:0] height_q;
	logic [WDIM_W-1:0] width_clamped;
	logic [HDIM_W-1:0] height_clamped;

	logic q_full;
	logic cmd_push;
	lmbc_pkg::cmd_t cmd;
	logic head_valid;
	lmbc_pkg::cmd_t head_cmd;
	logic pop;

	// registers keep the value already clamped to the supported range
	always_comb begin
		if (cfg_wdata < lmbc_pkg::CFG_W'(2)) begin
			width_clamped = WDIM_W'(2);
			height_clamped = HDIM_W'(2);
		end else begin
			width_clamped = (32'(cfg_wdata) > 32'(MAX_WIDTH)) ?
				WDIM_W'(MAX_WIDTH) : WDIM_W'(cfg_wdata);
			height_clamped = (32'(cfg_wdata) > 32'(MAX_HEIGHT)) ?
				HDIM_W'(MAX_HEIGHT) : HDIM_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WDIM_W'(WIDTH_INIT);
			height_q <= HDIM_W'(HEIGHT_INIT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lmbc_pkg::CFG_IMAGE_WIDTH: width_q <= width_clamped;
				lmbc_pkg::CFG_IMAGE_HEIGHT: height_q <= height_clamped;
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;

	lmbc_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_we),
		.width(width_q),
		.height(height_q),
		.in_valid(in_valid),
		.hold(q_full),
		.in_data(in_data),
		.cmd_push(cmd_push),
		.cmd(cmd)
	);

	lmbc_cmd_queue u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.push_cmd(cmd),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	lmbc_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.LABEL_BITS(LABEL_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_we),
		.width(width_q),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

// ===== hdl/lmbc_checker.sv =====
// port-level checks of the label map border classifier and their bind to the top level
// depends on lmbc_pkg and label_map_border_classifier
`default_nettype none

module lmbc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire lmbc_pkg::out_item_t out_data
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// an unstalled output always frees a queue slot in the cycle after
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> !in_stall)
		else $error("input stalled after an unstalled output cycle");

	// the queue can only fill behind an occupied output register
	a_full_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

endmodule

bind label_map_border_classifier lmbc_checker u_lmbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);

`default_nettype wire

// ===== verif/lmbc_class_checker.sv =====
// checker of the label map border classifier: predicts the border class of every pixel
// and compares each output transfer with it; depends on lmbc_pkg only
`default_nettype none

module lmbc_class_checker #(
	parameter int MAX_W = lmbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_H = lmbc_pkg::DEF_MAX_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire lmbc_pkg::in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire lmbc_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire lmbc_pkg::cfg_reg_t cfg_index,
	input wire logic [lmbc_pkg::CFG_W-1:0] cfg_wdata,
	output int error_count,
	output int pending,
	output int results_seen
);

	localparam int RING = MAX_W + 1;
	localparam int CFG_BITS = lmbc_pkg::CFG_W;

	logic [lmbc_pkg::LABEL_W-1:0] label_ring [RING];
	logic [lmbc_pkg::SCORE_W-1:0] score_ring [RING];
	logic [CFG_BITS-1:0] width_reg;
	logic [CFG_BITS-1:0] height_reg;
	int col;
	int row;
	int emitted;
	int ring_pos;
	bit draining;
	int errors;
	int seen;
	lmbc_pkg::out_item_t expected_pixels [$];

	function automatic int fit_dim(input logic [CFG_BITS-1:0] v, input int hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// two differing sides give a corner or, when opposite, a straight side
	function automatic logic [lmbc_pkg::SCORE_W-1:0] window_weight(input logic [3:0] code);
		int ones;
		ones = $countones(code);
		if (ones >= 3)
			return lmbc_pkg::WEIGHT_EDGE;
		if (ones == 2)
			return (code[0] == code[2]) ? lmbc_pkg::WEIGHT_SIDE : lmbc_pkg::WEIGHT_CORNER;
		return '0;
	endfunction

	function automatic lmbc_pkg::pixel_class_t class_of(
		input logic [lmbc_pkg::SCORE_W-1:0] score);
		case (score)
			lmbc_pkg::SCORE_STRAIGHT: return lmbc_pkg::CLS_STRAIGHT;
			lmbc_pkg::SCORE_OUTER: return lmbc_pkg::CLS_OUTER;
			lmbc_pkg::SCORE_INNER: return lmbc_pkg::CLS_INNER;
			lmbc_pkg::SCORE_END: return lmbc_pkg::CLS_END;
			lmbc_pkg::SCORE_DIAG: return lmbc_pkg::CLS_DIAG;
			default: return (score > lmbc_pkg::SCORE_EDGE_MIN) ?
				lmbc_pkg::CLS_EDGE : lmbc_pkg::CLS_NONE;
		endcase
	endfunction

	function automatic void restart_image();
		col = 0;
		row = 0;
		emitted = 0;
		ring_pos = 0;
		draining = 1'b0;
	endfunction

	function automatic void record_pixel(input logic [lmbc_pkg::SCORE_W-1:0] score,
		input int total);
		lmbc_pkg::out_item_t e;
		e.pixel_class = class_of(score);
		e.frame_last = (emitted + 1 >= total);
		expected_pixels.push_back(e);
		if (e.frame_last)
			restart_image();
		else
			emitted++;
	endfunction

	function automatic void predict_item(input lmbc_pkg::in_item_t item);
		int w;
		int h;
		int span;
		int slot;
		int tr_slot;
		int bl_slot;
		logic [lmbc_pkg::LABEL_W-1:0] tl;
		logic [lmbc_pkg::LABEL_W-1:0] tr;
		logic [lmbc_pkg::LABEL_W-1:0] bl;
		logic [3:0] code;
		logic [lmbc_pkg::SCORE_W-1:0] wt;
		logic [lmbc_pkg::SCORE_W-1:0] old_score;
		bit out_now;
		w = fit_dim(width_reg, MAX_W);
		h = fit_dim(height_reg, MAX_H);
		span = w + 1;
		// flush outside the drain phase is dropped
		if (!draining && item.op == lmbc_pkg::OP_FLUSH)
			return;
		if (ring_pos >= span)
			ring_pos = 0;
		slot = ring_pos;
		ring_pos = (slot + 1) % span;
		if (draining) begin
			record_pixel(score_ring[slot], w * h);
			return;
		end
		tr_slot = (slot + 1) % span;
		bl_slot = (slot + w) % span;
		wt = '0;
		old_score = score_ring[slot];
		out_now = (row >= 2) || (row == 1 && col >= 1);
		if (row >= 1 && col >= 1) begin
			tl = label_ring[slot];
			tr = label_ring[tr_slot];
			bl = label_ring[bl_slot];
			code = {bl != tl, item.label != bl, tr != item.label, tl != tr};
			wt = window_weight(code);
			score_ring[tr_slot] = score_ring[tr_slot] + wt;
			score_ring[bl_slot] = score_ring[bl_slot] + wt;
		end
		score_ring[slot] = wt;
		label_ring[slot] = item.label;
		if (col + 1 >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				row = 0;
				draining = 1'b1;
			end else begin
				row = row + 1;
			end
		end else begin
			col = col + 1;
		end
		if (out_now)
			record_pixel(old_score + wt, w * h);
	endfunction

	function automatic void check_result(input lmbc_pkg::out_item_t got);
		lmbc_pkg::out_item_t want;
		seen++;
		if (expected_pixels.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("result with nothing expected: class %0d last %0b",
					got.pixel_class, got.frame_last);
			return;
		end
		want = expected_pixels.pop_front();
		if (got.pixel_class !== want.pixel_class || got.frame_last !== want.frame_last) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected class %0d last %0b, got class %0d last %0b",
					want.pixel_class, want.frame_last, got.pixel_class, got.frame_last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_BITS'(lmbc_pkg::WIDTH_RESET);
			height_reg = CFG_BITS'(lmbc_pkg::HEIGHT_RESET);
			restart_image();
			expected_pixels.delete();
			errors = 0;
			seen = 0;
			error_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (in_valid && !in_stall)
				predict_item(in_data);
			if (cfg_we) begin
				if (cfg_index == lmbc_pkg::CFG_IMAGE_WIDTH)
					width_reg = cfg_wdata;
				else
					height_reg = cfg_wdata;
				restart_image();
			end
			error_count <= errors;
			pending <= expected_pixels.size();
			results_seen <= seen;
		end
	end

endmodule

`default_nettype wire

// ===== verif/label_map_border_classifier_tb.sv =====
// testbench top of the label map border classifier: clock, reset, stimulus and verdict
// depends on lmbc_pkg, label_map_border_classifier and lmbc_class_checker
`default_nettype none

module label_map_border_classifier_tb;

	localparam int TARGET_ITEMS = 400;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_WAIT = 20;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int LBL_BITS = lmbc_pkg::LABEL_W;
	localparam int CFG_BITS = lmbc_pkg::CFG_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lmbc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lmbc_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	lmbc_pkg::cfg_reg_t cfg_index = lmbc_pkg::CFG_IMAGE_WIDTH;
	logic [CFG_BITS-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int results_seen;
	int cycles = 0;
	int items_sent = 0;
	int settings = 0;
	int burst_left = 0;
	int hold_left = 0;
	int calm_left = 0;
	int roll;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;

	label_map_border_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	lmbc_class_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.error_count(errors),
		.pending(pending),
		.results_seen(results_seen)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// output side: short and long stalls, calm stretches, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			calm_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD - 1;
			long_hold_done <= 1'b1;
		end else if (calm_left > 0) begin
			out_stall <= 1'b0;
			calm_left <= calm_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				out_stall <= 1'b0;
				calm_left <= $urandom_range(30, 120);
			end else if (roll < 20) begin
				out_stall <= 1'b1;
				hold_left <= $urandom_range(0, 2);
			end else if (roll < 23) begin
				out_stall <= 1'b1;
				hold_left <= $urandom_range(10, 50);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int fit_dim(input int v, input int hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(30, 90);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one item and hold it until the transfer happens
	task automatic push_item(input logic op, input logic [LBL_BITS-1:0] lbl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{op: op, label: lbl};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_dims(input logic [CFG_BITS-1:0] wv, input logic [CFG_BITS-1:0] hv);
		cfg_we <= 1'b1;
		cfg_index <= lmbc_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata <= wv;
		@(posedge clk);
		cfg_index <= lmbc_pkg::CFG_IMAGE_HEIGHT;
		cfg_wdata <= hv;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	// labels mostly from a small palette so that regions and borders form
	task automatic run_frame(input int w, input int n_pix, input bit drain, input int n_labels);
		logic [LBL_BITS-1:0] palette [4];
		int i;
		for (i = 0; i < 4; i++)
			palette[i] = LBL_BITS'($urandom);
		for (i = 0; i < n_pix; i++) begin
			if ($urandom_range(0, 19) == 0)
				push_item(lmbc_pkg::OP_FLUSH, LBL_BITS'($urandom));
			if ($urandom_range(0, 9) == 0)
				push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'($urandom));
			else
				push_item(lmbc_pkg::OP_PIXEL, palette[$urandom_range(0, n_labels - 1)]);
		end
		if (drain) begin
			for (i = 0; i <= w; i++)
				push_item($urandom_range(0, 1) ? lmbc_pkg::OP_FLUSH : lmbc_pkg::OP_PIXEL,
					LBL_BITS'($urandom));
		end
	endtask

	initial begin
		int wr;
		int hr;
		int w;
		int h;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// part of a frame at the reset dimensions, aborted by the next write
		run_frame(lmbc_pkg::WIDTH_RESET, 40, 1'b0, 3);
		settle();

		// directed: both registers below the minimum, label extremes, every op
		set_dims('0, CFG_BITS'(1));
		push_item(lmbc_pkg::OP_FLUSH, '1);
		push_item(lmbc_pkg::OP_PIXEL, '0);
		push_item(lmbc_pkg::OP_PIXEL, '1);
		push_item(lmbc_pkg::OP_PIXEL, '1);
		push_item(lmbc_pkg::OP_PIXEL, '0);
		push_item(lmbc_pkg::OP_FLUSH, '0);
		// a pixel in the drain phase only drains
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(16'h1234));
		push_item(lmbc_pkg::OP_FLUSH, '1);
		settle();
		set_dims(CFG_BITS'(3), CFG_BITS'(2));
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(7));
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(7));
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(9));
		push_item(lmbc_pkg::OP_FLUSH, '0);
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(7));
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(9));
		push_item(lmbc_pkg::OP_PIXEL, LBL_BITS'(9));
		repeat (4) push_item(lmbc_pkg::OP_FLUSH, '0);
		settle();

		// registers at their top value, clamped; only the start of each frame goes in
		set_dims('1, CFG_BITS'(1));
		run_frame(lmbc_pkg::DEF_MAX_WIDTH, 24, 1'b0, 3);
		settle();
		set_dims('0, '1);
		run_frame(2, 30, 1'b0, 2);
		settle();

		// long output hold-off while the sender keeps offering items
		set_dims(CFG_BITS'(8), CFG_BITS'(6));
		long_hold_req = 1'b1;
		run_frame(8, 48, 1'b1, 3);
		settle();

		while (items_sent < TARGET_ITEMS) begin
			wr = $urandom_range(0, 7);
			hr = $urandom_range(0, 5);
			w = fit_dim(wr, lmbc_pkg::DEF_MAX_WIDTH);
			h = fit_dim(hr, lmbc_pkg::DEF_MAX_HEIGHT);
			set_dims(CFG_BITS'(wr), CFG_BITS'(hr));
			repeat ($urandom_range(1, 2))
				run_frame(w, w * h, 1'b1, $urandom_range(1, 4));
			if ($urandom_range(0, 3) == 0)
				run_frame(w, $urandom_range(1, w * h), 1'b0, $urandom_range(1, 4));
			settle();
		end

		$display("sent %0d input transfers, checked %0d results over %0d dimension settings",
			items_sent, results_seen, settings);
		$display("random frames up to 7x5, clamped registers, stray flushes and a %0d-cycle %s",
			LONG_HOLD, "output hold");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== label_map_border_classifier.f =====
hdl/lmbc_pkg.sv
hdl/lmbc_front.sv
hdl/lmbc_cmd_queue.sv
hdl/lmbc_back.sv
hdl/label_map_border_classifier.sv
hdl/lmbc_checker.sv
verif/lmbc_class_checker.sv
verif/label_map_border_classifier_tb.sv
